// ----- src/tdes_pkg.sv -----
package tdes_pkg;

  typedef enum logic [2:0] {
    REG_KEY_FIRST  = 3'd0,
    REG_KEY_SECOND = 3'd1,
    REG_KEY_THIRD  = 3'd2,
    REG_DIRECTION  = 3'd3,
    REG_KEY_OPTION = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_OPT_SINGLE = 2'd0,
    KEY_OPT_TWO    = 2'd1,
    KEY_OPT_THREE  = 2'd2,
    KEY_OPT_ALT    = 2'd3
  } key_opt_t;

  localparam int ROUNDS = 16;
  localparam int PASSES = 3;
  localparam int STAGES = ROUNDS * PASSES;

  localparam logic [5:0] KEY_SEL [56] = '{
    6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,  6'd0,  6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17,
    6'd9,  6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35,
    6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22, 6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21,
    6'd13, 6'd5,  6'd60, 6'd52, 6'd44, 6'd36, 6'd28, 6'd20, 6'd12, 6'd4,  6'd27, 6'd19, 6'd11, 6'd3};

  localparam logic [4:0] ROT_SUM [16] = '{
    5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

  localparam logic [5:0] SUB_SEL [48] = '{
    6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27, 6'd14, 6'd5,  6'd20, 6'd9,
    6'd22, 6'd18, 6'd11, 6'd3,  6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
    6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39, 6'd50, 6'd44, 6'd32, 6'd47,
    6'd43, 6'd48, 6'd38, 6'd55, 6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31};

  localparam logic [31:0] SBP [8][64] = '{
    '{32'h01010400,32'h00000000,32'h00010000,32'h01010404,32'h01010004,32'h00010404,32'h00000004,32'h00010000,
      32'h00000400,32'h01010400,32'h01010404,32'h00000400,32'h01000404,32'h01010004,32'h01000000,32'h00000004,
      32'h00000404,32'h01000400,32'h01000400,32'h00010400,32'h00010400,32'h01010000,32'h01010000,32'h01000404,
      32'h00010004,32'h01000004,32'h01000004,32'h00010004,32'h00000000,32'h00000404,32'h00010404,32'h01000000,
      32'h00010000,32'h01010404,32'h00000004,32'h01010000,32'h01010400,32'h01000000,32'h01000000,32'h00000400,
      32'h01010004,32'h00010000,32'h00010400,32'h01000004,32'h00000400,32'h00000004,32'h01000404,32'h00010404,
      32'h01010404,32'h00010004,32'h01010000,32'h01000404,32'h01000004,32'h00000404,32'h00010404,32'h01010400,
      32'h00000404,32'h01000400,32'h01000400,32'h00000000,32'h00010004,32'h00010400,32'h00000000,32'h01010004},
    '{32'h80108020,32'h80008000,32'h00008000,32'h00108020,32'h00100000,32'h00000020,32'h80100020,32'h80008020,
      32'h80000020,32'h80108020,32'h80108000,32'h80000000,32'h80008000,32'h00100000,32'h00000020,32'h80100020,
      32'h00108000,32'h00100020,32'h80008020,32'h00000000,32'h80000000,32'h00008000,32'h00108020,32'h80100000,
      32'h00100020,32'h80000020,32'h00000000,32'h00108000,32'h00008020,32'h80108000,32'h80100000,32'h00008020,
      32'h00000000,32'h00108020,32'h80100020,32'h00100000,32'h80008020,32'h80100000,32'h80108000,32'h00008000,
      32'h80100000,32'h80008000,32'h00000020,32'h80108020,32'h00108020,32'h00000020,32'h00008000,32'h80000000,
      32'h00008020,32'h80108000,32'h00100000,32'h80000020,32'h00100020,32'h80008020,32'h80000020,32'h00100020,
      32'h00108000,32'h00000000,32'h80008000,32'h00008020,32'h80000000,32'h80100020,32'h80108020,32'h00108000},
    '{32'h00000208,32'h08020200,32'h00000000,32'h08020008,32'h08000200,32'h00000000,32'h00020208,32'h08000200,
      32'h00020008,32'h08000008,32'h08000008,32'h00020000,32'h08020208,32'h00020008,32'h08020000,32'h00000208,
      32'h08000000,32'h00000008,32'h08020200,32'h00000200,32'h00020200,32'h08020000,32'h08020008,32'h00020208,
      32'h08000208,32'h00020200,32'h00020000,32'h08000208,32'h00000008,32'h08020208,32'h00000200,32'h08000000,
      32'h08020200,32'h08000000,32'h00020008,32'h00000208,32'h00020000,32'h08020200,32'h08000200,32'h00000000,
      32'h00000200,32'h00020008,32'h08020208,32'h08000200,32'h08000008,32'h00000200,32'h00000000,32'h08020008,
      32'h08000208,32'h00020000,32'h08000000,32'h08020208,32'h00000008,32'h00020208,32'h00020200,32'h08000008,
      32'h08020000,32'h08000208,32'h00000208,32'h08020000,32'h00020208,32'h00000008,32'h08020008,32'h00020200},
    '{32'h00802001,32'h00002081,32'h00002081,32'h00000080,32'h00802080,32'h00800081,32'h00800001,32'h00002001,
      32'h00000000,32'h00802000,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00800080,32'h00800001,
      32'h00000001,32'h00002000,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002001,32'h00002080,
      32'h00800081,32'h00000001,32'h00002080,32'h00800080,32'h00002000,32'h00802080,32'h00802081,32'h00000081,
      32'h00800080,32'h00800001,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00000000,32'h00802000,
      32'h00002080,32'h00800080,32'h00800081,32'h00000001,32'h00802001,32'h00002081,32'h00002081,32'h00000080,
      32'h00802081,32'h00000081,32'h00000001,32'h00002000,32'h00800001,32'h00002001,32'h00802080,32'h00800081,
      32'h00002001,32'h00002080,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002000,32'h00802080},
    '{32'h00000100,32'h02080100,32'h02080000,32'h42000100,32'h00080000,32'h00000100,32'h40000000,32'h02080000,
      32'h40080100,32'h00080000,32'h02000100,32'h40080100,32'h42000100,32'h42080000,32'h00080100,32'h40000000,
      32'h02000000,32'h40080000,32'h40080000,32'h00000000,32'h40000100,32'h42080100,32'h42080100,32'h02000100,
      32'h42080000,32'h40000100,32'h00000000,32'h42000000,32'h02080100,32'h02000000,32'h42000000,32'h00080100,
      32'h00080000,32'h42000100,32'h00000100,32'h02000000,32'h40000000,32'h02080000,32'h42000100,32'h40080100,
      32'h02000100,32'h40000000,32'h42080000,32'h02080100,32'h40080100,32'h00000100,32'h02000000,32'h42080000,
      32'h42080100,32'h00080100,32'h42000000,32'h42080100,32'h02080000,32'h00000000,32'h40080000,32'h42000000,
      32'h00080100,32'h02000100,32'h40000100,32'h00080000,32'h00000000,32'h40080000,32'h02080100,32'h40000100},
    '{32'h20000010,32'h20400000,32'h00004000,32'h20404010,32'h20400000,32'h00000010,32'h20404010,32'h00400000,
      32'h20004000,32'h00404010,32'h00400000,32'h20000010,32'h00400010,32'h20004000,32'h20000000,32'h00004010,
      32'h00000000,32'h00400010,32'h20004010,32'h00004000,32'h00404000,32'h20004010,32'h00000010,32'h20400010,
      32'h20400010,32'h00000000,32'h00404010,32'h20404000,32'h00004010,32'h00404000,32'h20404000,32'h20000000,
      32'h20004000,32'h00000010,32'h20400010,32'h00404000,32'h20404010,32'h00400000,32'h00004010,32'h20000010,
      32'h00400000,32'h20004000,32'h20000000,32'h00004010,32'h20000010,32'h20404010,32'h00404000,32'h20400000,
      32'h00404010,32'h20404000,32'h00000000,32'h20400010,32'h00000010,32'h00004000,32'h20400000,32'h00404010,
      32'h00004000,32'h00400010,32'h20004010,32'h00000000,32'h20404000,32'h20000000,32'h00400010,32'h20004010},
    '{32'h00200000,32'h04200002,32'h04000802,32'h00000000,32'h00000800,32'h04000802,32'h00200802,32'h04200800,
      32'h04200802,32'h00200000,32'h00000000,32'h04000002,32'h00000002,32'h04000000,32'h04200002,32'h00000802,
      32'h04000800,32'h00200802,32'h00200002,32'h04000800,32'h04000002,32'h04200000,32'h04200800,32'h00200002,
      32'h04200000,32'h00000800,32'h00000802,32'h04200802,32'h00200800,32'h00000002,32'h04000000,32'h00200800,
      32'h04000000,32'h00200800,32'h00200000,32'h04000802,32'h04000802,32'h04200002,32'h04200002,32'h00000002,
      32'h00200002,32'h04000000,32'h04000800,32'h00200000,32'h04200800,32'h00000802,32'h00200802,32'h04200800,
      32'h00000802,32'h04000002,32'h04200802,32'h04200000,32'h00200800,32'h00000000,32'h00000002,32'h04200802,
      32'h00000000,32'h00200802,32'h04200000,32'h00000800,32'h04000002,32'h04000800,32'h00000800,32'h00200002},
    '{32'h10001040,32'h00001000,32'h00040000,32'h10041040,32'h10000000,32'h10001040,32'h00000040,32'h10000000,
      32'h00040040,32'h10040000,32'h10041040,32'h00041000,32'h10041000,32'h00041040,32'h00001000,32'h00000040,
      32'h10040000,32'h10000040,32'h10001000,32'h00001040,32'h00041000,32'h00040040,32'h10040040,32'h10041000,
      32'h00001040,32'h00000000,32'h00000000,32'h10040040,32'h10000040,32'h10001000,32'h00041040,32'h00040000,
      32'h00041040,32'h00040000,32'h10041000,32'h00001000,32'h00000040,32'h10040040,32'h00001000,32'h00041040,
      32'h10001000,32'h00000040,32'h10000040,32'h10040000,32'h10040040,32'h10000000,32'h00040000,32'h10001040,
      32'h00000000,32'h10041040,32'h00040040,32'h10000040,32'h10040000,32'h10001000,32'h10001040,32'h00000000,
      32'h10041040,32'h00041000,32'h00041000,32'h00001040,32'h00001040,32'h00040040,32'h10000000,32'h10041000}};

  function automatic logic [63:0] subkey(input logic [63:0] key, input int idx);
    logic [55:0] sel;
    logic [55:0] rot;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] k0;
    logic [31:0] k1;
    int r;
    int l;
    sel = '0;
    rot = '0;
    p = '0;
    q = '0;
    for (int j = 0; j < 56; j++) begin
      sel[j] = key[63 - int'(KEY_SEL[j])];
    end
    r = int'(ROT_SUM[idx]);
    for (int j = 0; j < 28; j++) begin
      l = j + r;
      rot[j] = sel[(l < 28) ? l : l - 28];
    end
    for (int j = 28; j < 56; j++) begin
      l = j + r;
      rot[j] = sel[(l < 56) ? l : l - 28];
    end
    for (int j = 0; j < 24; j++) begin
      p[23 - j] = rot[SUB_SEL[j]];
      q[23 - j] = rot[SUB_SEL[j + 24]];
    end
    k0 = ((p & 32'h00fc0000) << 6) | ((p & 32'h00000fc0) << 10)
       | ((q & 32'h00fc0000) >> 10) | ((q & 32'h00000fc0) >> 6);
    k1 = ((p & 32'h0003f000) << 12) | ((p & 32'h0000003f) << 16)
       | ((q & 32'h0003f000) >> 4) | (q & 32'h0000003f);
    return {k0, k1};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] half, input logic [63:0] sk);
    logic [31:0] w;
    logic [31:0] f;
    w = {half[3:0], half[31:4]} ^ sk[63:32];
    f = SBP[6][w[5:0]] | SBP[4][w[13:8]] | SBP[2][w[21:16]] | SBP[0][w[29:24]];
    w = half ^ sk[31:0];
    f = f | SBP[7][w[5:0]] | SBP[5][w[13:8]] | SBP[3][w[21:16]] | SBP[1][w[29:24]];
    return f;
  endfunction

  function automatic logic [63:0] init_perm(input logic [63:0] blk);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    l = blk[63:32];
    r = blk[31:0];
    t = ((l >> 4) ^ r) & 32'h0f0f0f0f;  r = r ^ t; l = l ^ (t << 4);
    t = ((l >> 16) ^ r) & 32'h0000ffff; r = r ^ t; l = l ^ (t << 16);
    t = ((r >> 2) ^ l) & 32'h33333333;  l = l ^ t; r = r ^ (t << 2);
    t = ((r >> 8) ^ l) & 32'h00ff00ff;  l = l ^ t; r = r ^ (t << 8);
    r = {r[30:0], r[31]};
    t = (l ^ r) & 32'haaaaaaaa; l = l ^ t; r = r ^ t;
    l = {l[30:0], l[31]};
    return {l, r};
  endfunction

  function automatic logic [63:0] final_perm(input logic [63:0] lr);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    l = lr[63:32];
    r = lr[31:0];
    r = {r[0], r[31:1]};
    t = (l ^ r) & 32'haaaaaaaa; l = l ^ t; r = r ^ t;
    l = {l[0], l[31:1]};
    t = ((l >> 8) ^ r) & 32'h00ff00ff;  r = r ^ t; l = l ^ (t << 8);
    t = ((l >> 2) ^ r) & 32'h33333333;  r = r ^ t; l = l ^ (t << 2);
    t = ((r >> 16) ^ l) & 32'h0000ffff; l = l ^ t; r = r ^ (t << 16);
    t = ((r >> 4) ^ l) & 32'h0f0f0f0f;  l = l ^ t; r = r ^ (t << 4);
    return {r, l};
  endfunction

endpackage

// ----- src/tdes_stream_if.sv -----
interface tdes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_block;
  modport source (output valid, output data_block, input ready);
  modport sink (input valid, input data_block, output ready);
endinterface

interface tdes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;
  modport source (output valid, output result_block, input ready);
  modport sink (input valid, input result_block, output ready);
endinterface

// ----- src/triple_des_block_cipher_core.sv -----
// Triple DES (EDE) cipher engine, one Feistel round per pipeline stage.
// Input channel in_ch carries a 64-bit data_block; output channel out_ch
// carries the 64-bit result_block. A word moves when valid and ready are high.
// Keys, direction and key option are written through cfg_we/cfg_index/
// cfg_data: 0 key_first, 1 key_second, 2 key_third, 3 direction (1 encrypt),
// 4 key_option (0 single, 1 two-key, 2 three-key). Write them only while
// the pipeline is empty; subkeys are wired straight off the key registers.
// Single DES runs as E(K1) D(K1) E(K1), so every word crosses all stages.
// Pipeline: 48 register stages (three passes of 16 rounds); the first stage
// loads at the input accept edge, and the result is taken from the last stage.
// Throughput: one word per cycle while the output is not stalled.
// When out_ch.ready is low and a result is waiting, the whole pipeline
// holds and in_ch.ready drops; nothing is dropped or repeated.
// Reset clears all stage valid bits, keys to zero, direction to encrypt
// and key option to single DES.
module triple_des_block_cipher_core
  import tdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  tdes_in_if.sink     in_ch,
  tdes_out_if.source  out_ch
);

  logic [63:0] key_first;
  logic [63:0] key_second;
  logic [63:0] key_third;
  logic        direction;
  logic [1:0]  key_option;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first  <= '0;
      key_second <= '0;
      key_third  <= '0;
      direction  <= 1'b1;
      key_option <= KEY_OPT_SINGLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_FIRST:  key_first  <= cfg_data;
        REG_KEY_SECOND: key_second <= cfg_data;
        REG_KEY_THIRD:  key_third  <= cfg_data;
        REG_DIRECTION:  direction  <= cfg_data[0];
        REG_KEY_OPTION: key_option <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [63:0] last_key;
  logic [63:0] mid_key;

  assign last_key = key_option[1] ? key_third : key_first;
  assign mid_key  = (key_option == KEY_OPT_SINGLE) ? key_first : key_second;

  logic        adv;
  logic [STAGES-1:0] vld;
  logic [63:0] lr [STAGES];

  assign adv          = !vld[STAGES-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld[STAGES-1];
  assign out_ch.result_block = final_perm(lr[STAGES-1]);

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int PASS = s / ROUNDS;
    localparam int RND  = s % ROUNDS;
    logic [63:0] key_s;
    logic        enc_s;
    logic [63:0] lr_in;
    logic        vld_in;
    logic [63:0] sk;

    if (PASS == 0) begin : g_p0
      assign key_s = direction ? key_first : last_key;
      assign enc_s = direction;
    end else if (PASS == 1) begin : g_p1
      assign key_s = mid_key;
      assign enc_s = !direction;
    end else begin : g_p2
      assign key_s = direction ? last_key : key_first;
      assign enc_s = direction;
    end

    if (s == 0) begin : g_head
      assign lr_in  = init_perm(in_ch.data_block);
      assign vld_in = in_ch.valid;
    end else if (RND == 0) begin : g_pass
      assign lr_in  = init_perm(final_perm(lr[s-1]));
      assign vld_in = vld[s-1];
    end else begin : g_mid
      assign lr_in  = lr[s-1];
      assign vld_in = vld[s-1];
    end

    assign sk = enc_s ? subkey(key_s, RND) : subkey(key_s, ROUNDS - 1 - RND);

    tdes_round u_round (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .vld_in  (vld_in),
      .lr_in   (lr_in),
      .sk      (sk),
      .vld_out (vld[s]),
      .lr_out  (lr[s])
    );
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-1] && !out_ch.ready) |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> vld[0])
    else $error("accepted word missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

// ----- src/tdes_round.sv -----
module tdes_round
  import tdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        vld_in,
  input  logic [63:0] lr_in,
  input  logic [63:0] sk,
  output logic        vld_out,
  output logic [63:0] lr_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lr_out <= {lr_in[31:0], lr_in[63:32] ^ feistel(lr_in[31:0], sk)};
    end
  end

endmodule
